>>> rtl/rcps_pkg.sv
// rcps_pkg: shared types and constants of the raycast column pixel source
// used by rcps_csr, rcps_front, rcps_divider and the top file, depends on nothing
package rcps_pkg;

   localparam int MAX_SCREEN_DIM = 4096;
   localparam int DIM_W = 13;
   localparam int COLOR_W = 24;
   localparam int STRIP_W = 22;
   localparam int DIVIDEND_W = 32;
   localparam int DIVISOR_W = 23;
   localparam int TEXEL_AXIS_W = 8;

   typedef enum logic [1:0] {
      KIND_CEILING = 2'd0,
      KIND_WALL    = 2'd1,
      KIND_FLOOR   = 2'd2
   } pixel_kind_type;

   typedef enum logic [1:0] {
      CSR_SCREEN_HEIGHT = 2'd0,
      CSR_SCREEN_WIDTH  = 2'd1,
      CSR_CEILING_COLOR = 2'd2,
      CSR_FLOOR_COLOR   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [DIM_W-1:0]   screen_height;
      logic [DIM_W-1:0]   screen_width;
      logic [COLOR_W-1:0] ceiling_color;
      logic [COLOR_W-1:0] floor_color;
   } cfg_type;

   typedef struct packed {
      logic [11:0]        pixel_row;
      logic [11:0]        pixel_column;
      logic [STRIP_W-1:0] strip_height;
      logic               hit_vertical;
      logic [15:0]        hit_x;
      logic [15:0]        hit_y;
      logic [1:0]         texture_select;
   } req_type;

   typedef struct packed {
      logic                    write_enable;
      pixel_kind_type          pixel_kind;
      logic [23:0]             frame_address;
      logic [COLOR_W-1:0]      flat_color;
      logic [1:0]              texture_number;
      logic [TEXEL_AXIS_W-1:0] texel_x;
   } side_type;

   typedef struct packed {
      logic [DIVIDEND_W-1:0]   remainder;
      logic [DIVISOR_W-1:0]    divisor;
      logic [TEXEL_AXIS_W-1:0] quotient;
      logic                    saturate;
      logic                    nonzero;
   } div_type;

   typedef struct packed {
      side_type side;
      div_type  div;
   } div_item_type;

endpackage

>>> rtl/rcps_ifs.sv
// rcps_ifs: valid/ready channel interfaces for pixel requests, results and csr writes
// depends on nothing
interface rcps_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] pixel_row;
   logic [11:0] pixel_column;
   logic [21:0] strip_height;
   logic        hit_vertical;
   logic [15:0] hit_x;
   logic [15:0] hit_y;
   logic [1:0]  texture_select;

   modport source (output valid, pixel_row, pixel_column, strip_height, hit_vertical,
                   hit_x, hit_y, texture_select, input ready);
   modport sink (input valid, pixel_row, pixel_column, strip_height, hit_vertical,
                 hit_x, hit_y, texture_select, output ready);
endinterface

interface rcps_rsp_if;
   logic        valid;
   logic        ready;
   logic        write_enable;
   logic [1:0]  pixel_kind;
   logic [23:0] frame_address;
   logic [23:0] flat_color;
   logic [1:0]  texture_number;
   logic [11:0] texel_index;

   modport source (output valid, write_enable, pixel_kind, frame_address, flat_color,
                   texture_number, texel_index, input ready);
   modport sink (input valid, write_enable, pixel_kind, frame_address, flat_color,
                 texture_number, texel_index, output ready);
endinterface

interface rcps_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [23:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/rcps_csr.sv
// rcps_csr: configuration registers written over the csr channel
// depends on rcps_pkg and rcps_ifs
module rcps_csr (
   input  logic              clock,
   input  logic              reset,
   rcps_csr_if.sink          csr_chan,
   output rcps_pkg::cfg_type cfg
);

   rcps_pkg::cfg_type cfg_ff;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_height <= 13'd480;
         cfg_ff.screen_width  <= 13'd640;
         cfg_ff.ceiling_color <= 24'd0;
         cfg_ff.floor_color   <= 24'd0;
      end else if (csr_chan.valid) begin
         case (rcps_pkg::csr_index_type'(csr_chan.index))
            rcps_pkg::CSR_SCREEN_HEIGHT: cfg_ff.screen_height <= csr_chan.data[12:0];
            rcps_pkg::CSR_SCREEN_WIDTH:  cfg_ff.screen_width  <= csr_chan.data[12:0];
            rcps_pkg::CSR_CEILING_COLOR: cfg_ff.ceiling_color <= csr_chan.data;
            rcps_pkg::CSR_FLOOR_COLOR:   cfg_ff.floor_color   <= csr_chan.data;
            default: ;
         endcase
      end
   end

endmodule

>>> rtl/rcps_front.sv
// rcps_front: three pipeline stages that classify the pixel, form its address,
// reduce the texel column and set up the texel row division; depends on rcps_pkg
module rcps_front #(
   parameter int TILE_SIZE = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  rcps_pkg::cfg_type          cfg,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  rcps_pkg::req_type          in_item,
   output logic                       out_valid,
   input  logic                       out_ready,
   output rcps_pkg::div_item_type     out_item
);

   localparam logic [31:0] TILE_W32 = 32'(TILE_SIZE);

   typedef struct packed {
      logic                     write_enable;
      rcps_pkg::pixel_kind_type pixel_kind;
      logic [23:0]              flat_color;
      logic [1:0]               texture_number;
      logic [11:0]              row;
      logic [11:0]              col;
      logic [12:0]              height;
      logic [12:0]              width;
      logic [21:0]              strip;
      logic [20:0]              sample;
      logic [15:0]              coord;
   } f0_type;

   typedef struct packed {
      logic                     write_enable;
      rcps_pkg::pixel_kind_type pixel_kind;
      logic [23:0]              flat_color;
      logic [1:0]               texture_number;
      logic [11:0]              col;
      logic [21:0]              strip;
      logic [22:0]              pos;
      logic [20:0]              neg;
      logic [23:0]              row_base;
      logic [15:0]              coord_rem;
   } f1_type;

   f0_type f0_in, f0_ff;
   f1_type f1_in, f1_ff;
   rcps_pkg::div_item_type f2_in, f2_ff;
   logic v0_ff, v1_ff, v2_ff;
   logic r0, r1, r2;

   logic [12:0] h_sat, w_sat;
   logic [20:0] c512;
   logic        c_gt_s, c_ge_s, ceil_hit, floor_hit;
   logic [21:0] ceil_diff;
   logic [22:0] floor_sum;
   logic [8:0]  adj;
   logic [24:0] prod;
   logic [15:0] rem_a, rem_b;
   logic [22:0] n_val;

   assign r2 = !v2_ff || out_ready;
   assign r1 = !v1_ff || r2;
   assign r0 = !v0_ff || r1;
   assign in_ready = r0;
   assign out_valid = v2_ff;
   assign out_item = f2_ff;

   // classify
   always_comb begin
      h_sat = (cfg.screen_height > 13'(rcps_pkg::MAX_SCREEN_DIM)) ?
              13'(rcps_pkg::MAX_SCREEN_DIM) : cfg.screen_height;
      w_sat = (cfg.screen_width > 13'(rcps_pkg::MAX_SCREEN_DIM)) ?
              13'(rcps_pkg::MAX_SCREEN_DIM) : cfg.screen_width;
      c512 = {h_sat[12:1], 9'd0};
      c_gt_s = {1'b0, c512} > in_item.strip_height;
      c_ge_s = {1'b0, c512} >= in_item.strip_height;
      ceil_diff = {1'b0, c512} - in_item.strip_height;
      ceil_hit = c_gt_s && ({1'b0, in_item.pixel_row} < ceil_diff[21:9]);
      floor_sum = {2'b0, c512} + {1'b0, in_item.strip_height};
      floor_hit = {2'b0, in_item.pixel_row} >= floor_sum[22:9];
      adj = c_ge_s ? (9'd0 - in_item.strip_height[8:0]) : 9'd0;

      f0_in.write_enable = ({1'b0, in_item.pixel_row} < h_sat) &&
                           ({1'b0, in_item.pixel_column} < w_sat);
      f0_in.flat_color = 24'd0;
      f0_in.texture_number = 2'd0;
      if (floor_hit) begin
         f0_in.pixel_kind = rcps_pkg::KIND_FLOOR;
         f0_in.flat_color = cfg.floor_color;
      end else if (ceil_hit) begin
         f0_in.pixel_kind = rcps_pkg::KIND_CEILING;
         f0_in.flat_color = cfg.ceiling_color;
      end else begin
         f0_in.pixel_kind = rcps_pkg::KIND_WALL;
         f0_in.texture_number = in_item.texture_select;
      end
      f0_in.row = in_item.pixel_row;
      f0_in.col = in_item.pixel_column;
      f0_in.height = h_sat;
      f0_in.width = w_sat;
      f0_in.strip = in_item.strip_height;
      f0_in.sample = {in_item.pixel_row, adj};
      f0_in.coord = in_item.hit_vertical ? in_item.hit_y : in_item.hit_x;
   end

   // sample position, row base address, upper half of the texel column reduction
   always_comb begin
      prod = f0_ff.row * f0_ff.width;
      rem_a = f0_ff.coord;
      for (int i = 15; i >= 8; i--) begin
         if ({16'd0, rem_a} >= (TILE_W32 << i)) begin
            rem_a = rem_a - 16'(TILE_W32 << i);
         end
      end
      f1_in.write_enable = f0_ff.write_enable;
      f1_in.pixel_kind = f0_ff.pixel_kind;
      f1_in.flat_color = f0_ff.flat_color;
      f1_in.texture_number = f0_ff.texture_number;
      f1_in.col = f0_ff.col;
      f1_in.strip = f0_ff.strip;
      f1_in.pos = {2'b0, f0_ff.sample} + {1'b0, f0_ff.strip};
      f1_in.neg = {f0_ff.height, 8'd0};
      f1_in.row_base = prod[23:0];
      f1_in.coord_rem = rem_a;
   end

   // final address, lower half of the reduction, division setup
   always_comb begin
      rem_b = f1_ff.coord_rem;
      for (int i = 7; i >= 0; i--) begin
         if ({16'd0, rem_b} >= (TILE_W32 << i)) begin
            rem_b = rem_b - 16'(TILE_W32 << i);
         end
      end
      n_val = f1_ff.pos - {2'b0, f1_ff.neg};
      f2_in.side.write_enable = f1_ff.write_enable;
      f2_in.side.pixel_kind = f1_ff.pixel_kind;
      f2_in.side.frame_address = f1_ff.row_base + {12'd0, f1_ff.col};
      f2_in.side.flat_color = f1_ff.flat_color;
      f2_in.side.texture_number = f1_ff.texture_number;
      f2_in.side.texel_x = rem_b[7:0];
      f2_in.div.divisor = {f1_ff.strip, 1'b0};
      f2_in.div.remainder = {9'd0, n_val} * TILE_W32;
      f2_in.div.quotient = 8'd0;
      f2_in.div.nonzero = (f1_ff.pos > {2'b0, f1_ff.neg}) && (f1_ff.strip != 22'd0);
      f2_in.div.saturate = n_val >= {f1_ff.strip, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (r0) v0_ff <= in_valid;
         if (r1) v1_ff <= v0_ff;
         if (r2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (r0) f0_ff <= f0_in;
      if (r1) f1_ff <= f1_in;
      if (r2) f2_ff <= f2_in;
   end

endmodule

>>> rtl/rcps_divider.sv
// rcps_divider: restoring division of the texel row, one quotient bit per stage
// depends on rcps_pkg
module rcps_divider #(
   parameter int TILE_SIZE = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  rcps_pkg::div_item_type in_item,
   output logic                   out_valid,
   input  logic                   out_ready,
   output rcps_pkg::div_item_type out_item
);

   localparam int QW = $clog2(TILE_SIZE);

   rcps_pkg::div_item_type src_item [QW+1];
   logic [QW:0]            src_valid;
   logic [QW:0]            stage_ready;
   rcps_pkg::div_item_type item_ff [QW];
   logic [QW-1:0]          valid_ff;

   assign src_item[0] = in_item;
   assign src_valid[0] = in_valid;
   assign stage_ready[QW] = out_ready;
   assign in_ready = stage_ready[0];
   assign out_valid = src_valid[QW];
   assign out_item = src_item[QW];

   for (genvar k = 0; k < QW; k++) begin : g_step
      localparam int SH = QW - 1 - k;
      rcps_pkg::div_item_type item_in;
      logic [31:0] trial;

      assign stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      assign src_item[k+1] = item_ff[k];
      assign src_valid[k+1] = valid_ff[k];

      always_comb begin
         item_in = src_item[k];
         trial = {9'd0, src_item[k].div.divisor} << SH;
         if (src_item[k].div.remainder >= trial) begin
            item_in.div.remainder = src_item[k].div.remainder - trial;
            item_in.div.quotient[SH] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (stage_ready[k]) begin
            valid_ff[k] <= src_valid[k];
         end
      end

      always_ff @(posedge clock) begin
         if (stage_ready[k]) item_ff[k] <= item_in;
      end
   end

endmodule

>>> rtl/raycast_column_pixel_source_top.sv
// raycast_column_pixel_source_top: csr block, front stages, texel row divider, output register
// depends on rcps_pkg, rcps_ifs, rcps_csr, rcps_front and rcps_divider
//
// channel    role    carries
// req_chan   sink    pixel row/column, strip height, wall hit, texture select
// rsp_chan   source  write enable, kind, frame address, flat color, texel
// csr_chan   sink    register index and write data, always ready
//
// one item per cycle unless rsp_chan stalls; an item passes through, in order:
// three front stages, one divider stage per texel row bit, one output register
// reset clears every valid bit and loads the register reset values
// each stage holds its item while the stage after it is full and stalled
module raycast_column_pixel_source_top #(
   parameter int TILE_SIZE = 64
) (
   input  logic     clock,
   input  logic     reset,
   rcps_req_if.sink   req_chan,
   rcps_rsp_if.source rsp_chan,
   rcps_csr_if.sink   csr_chan
);

   rcps_pkg::cfg_type      cfg;
   rcps_pkg::req_type      req_item;
   rcps_pkg::div_item_type front_item, div_item;
   logic front_valid, front_ready, div_valid, div_ready;

   logic [7:0]  ty;
   logic [16:0] texel_sum;
   logic        is_wall;

   logic                     valid_ff;
   logic                     we_ff, we_in;
   rcps_pkg::pixel_kind_type kind_ff, kind_in;
   logic [23:0]              addr_ff, addr_in;
   logic [23:0]              color_ff, color_in;
   logic [1:0]               tnum_ff, tnum_in;
   logic [11:0]              tidx_ff, tidx_in;

   assign req_item.pixel_row = req_chan.pixel_row;
   assign req_item.pixel_column = req_chan.pixel_column;
   assign req_item.strip_height = req_chan.strip_height;
   assign req_item.hit_vertical = req_chan.hit_vertical;
   assign req_item.hit_x = req_chan.hit_x;
   assign req_item.hit_y = req_chan.hit_y;
   assign req_item.texture_select = req_chan.texture_select;

   rcps_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   rcps_front #(.TILE_SIZE(TILE_SIZE)) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_item   (req_item),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_item  (front_item)
   );

   rcps_divider #(.TILE_SIZE(TILE_SIZE)) u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_item   (front_item),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_item  (div_item)
   );

   assign div_ready = !valid_ff || rsp_chan.ready;

   // texel row saturation and result gating
   always_comb begin
      if (div_item.div.saturate && div_item.div.nonzero) begin
         ty = 8'(TILE_SIZE - 1);
      end else if (div_item.div.nonzero) begin
         ty = div_item.div.quotient;
      end else begin
         ty = 8'd0;
      end
      texel_sum = {9'd0, div_item.side.texel_x} + 17'(TILE_SIZE) * {9'd0, ty};
      is_wall = div_item.side.pixel_kind == rcps_pkg::KIND_WALL;
      we_in = div_item.side.write_enable;
      kind_in = we_in ? div_item.side.pixel_kind : rcps_pkg::KIND_CEILING;
      addr_in = we_in ? div_item.side.frame_address : 24'd0;
      color_in = we_in ? div_item.side.flat_color : 24'd0;
      tnum_in = we_in ? div_item.side.texture_number : 2'd0;
      tidx_in = (we_in && is_wall) ? texel_sum[11:0] : 12'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (div_ready) begin
         valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (div_ready) begin
         we_ff <= we_in;
         kind_ff <= kind_in;
         addr_ff <= addr_in;
         color_ff <= color_in;
         tnum_ff <= tnum_in;
         tidx_ff <= tidx_in;
      end
   end

   assign rsp_chan.valid = valid_ff;
   assign rsp_chan.write_enable = we_ff;
   assign rsp_chan.pixel_kind = kind_ff;
   assign rsp_chan.frame_address = addr_ff;
   assign rsp_chan.flat_color = color_ff;
   assign rsp_chan.texture_number = tnum_ff;
   assign rsp_chan.texel_index = tidx_ff;

   a_offscreen_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !we_ff) |-> (addr_ff == 24'd0 && color_ff == 24'd0 &&
                                tidx_ff == 12'd0 && tnum_ff == 2'd0 &&
                                kind_ff == rcps_pkg::KIND_CEILING))
      else $error("off-screen item carries nonzero fields");

   a_wall_no_color: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff == rcps_pkg::KIND_WALL) |-> (color_ff == 24'd0))
      else $error("wall item carries a flat color");

   a_flat_no_texel: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff != rcps_pkg::KIND_WALL) |-> (tidx_ff == 12'd0 && tnum_ff == 2'd0))
      else $error("ceiling or floor item carries texel data");

endmodule
